[rtl/core/gfpw_pkg.sv]
// ----------------------------------------------------------------------------
// gfpw_pkg
// shared types and field widths of the gray4 framebuffer pixel writer
// ----------------------------------------------------------------------------
package gfpw_pkg;

  localparam int unsigned CMD_W       = 2;
  localparam int unsigned COORD_W     = 16;
  localparam int unsigned GRAY_W      = 4;
  localparam int unsigned RGB_W       = 16;
  localparam int unsigned BYTE_ADDR_W = 18;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned REG_W       = 11;
  localparam int unsigned ROT_W       = 2;
  localparam int unsigned CFG_INDEX_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_DIRECT = 2'd0,
    CMD_STREAM = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ROTATION      = 3'd0,
    REG_FRAME_WIDTH   = 3'd1,
    REG_FRAME_HEIGHT  = 3'd2,
    REG_WINDOW_LEFT   = 3'd3,
    REG_WINDOW_RIGHT  = 3'd4,
    REG_WINDOW_TOP    = 3'd5,
    REG_WINDOW_BOTTOM = 3'd6
  } cfg_reg_t;

endpackage

[rtl/core/gfpw_channels.sv]
// ----------------------------------------------------------------------------
// gfpw channels
// valid/ready channels for pixel items, result items and register writes
// ----------------------------------------------------------------------------
interface gfpw_pixel_if;
  import gfpw_pkg::*;

  logic                          valid;
  logic                          ready;
  cmd_t                          command;
  logic signed [COORD_W-1:0]     pixel_x;
  logic signed [COORD_W-1:0]     pixel_y;
  logic        [GRAY_W-1:0]      gray_level;
  logic        [RGB_W-1:0]       pixel_rgb565;
  logic                          swap_bytes;
  logic                          last_pixel;
  logic        [BYTE_ADDR_W-1:0] byte_address;

  modport source (
    output valid, command, pixel_x, pixel_y, gray_level, pixel_rgb565,
           swap_bytes, last_pixel, byte_address,
    input  ready
  );

  modport sink (
    input  valid, command, pixel_x, pixel_y, gray_level, pixel_rgb565,
           swap_bytes, last_pixel, byte_address,
    output ready
  );
endinterface

interface gfpw_result_if;
  import gfpw_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] read_byte;
  logic              pixel_written;

  modport source (output valid, read_byte, pixel_written, input ready);
  modport sink (input valid, read_byte, pixel_written, output ready);
endinterface

interface gfpw_cfg_if;
  import gfpw_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [REG_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/gray4_framebuffer_pixel_writer.sv]
// ----------------------------------------------------------------------------
// gray4_framebuffer_pixel_writer
// packed 4-bit gray framebuffer with direct, streamed and read transactions
// ----------------------------------------------------------------------------
// One pixel transaction is taken per clock while input ready is high. Stage
// one rotates and clips the coordinates and converts RGB565 to gray for
// streamed pixels, stage two forms the byte address and issues the store
// read, stage three merges the nibble and writes the byte back, the
// output register holds the result. The store is one
// synchronous memory with one read and one write port; a write from stage
// three is forwarded to the read entering it in the same cycle, so no stall
// arises between dependent pixels. Input ready drops only when the output
// register is held by the sink and every stage behind it is full. The store
// has no reset and needs no clearing pass; register writes are always ready.
// ----------------------------------------------------------------------------
module gray4_framebuffer_pixel_writer #(
  parameter int unsigned STORE_BYTES = 262144,
  parameter int unsigned MAX_DIM     = 1024
) (
  input  logic           clk,
  input  logic           rst,
  gfpw_pixel_if.sink     pixel,
  gfpw_result_if.source  result,
  gfpw_cfg_if.sink       cfg
);
  import gfpw_pkg::*;

  localparam int unsigned AW = $clog2(STORE_BYTES);
  localparam int unsigned DW = $clog2(MAX_DIM + 1);
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned SUM_W = 10;
  localparam int unsigned RECIP_W = 20;
  localparam logic [RECIP_W-1:0] GRAY_RECIP = 20'd683;
  localparam int unsigned GRAY_SHIFT = 15;

  // configuration
  logic [ROT_W-1:0] rotation;
  logic [REG_W-1:0] frame_width;
  logic [REG_W-1:0] frame_height;
  logic [REG_W-1:0] window_left;
  logic [REG_W-1:0] window_right;
  logic [REG_W-1:0] window_bottom;

  // stream cursor
  logic [REG_W-1:0] cursor_x;
  logic [REG_W-1:0] cursor_y;
  logic [REG_W-1:0] row_start;
  logic             window_exhausted;
  logic [REG_W-1:0] cursor_x_next;
  logic [REG_W-1:0] cursor_y_next;
  logic [REG_W-1:0] row_start_next;
  logic             window_exhausted_next;

  // handshake and stage control
  logic cfg_fire;
  logic in_fire;
  logic out_free;
  logic p1_valid, p1_free, p1_adv;
  logic p2_valid, p2_free, p2_adv;
  logic p3_valid, p3_free, p3_adv;
  logic res_valid;

  // stage one
  cmd_t                   p1_cmd;
  logic [COORD_W-1:0]     p1_x;
  logic [COORD_W-1:0]     p1_y;
  logic [GRAY_W-1:0]      p1_gray_level;
  logic [RGB_W-1:0]       p1_color;
  logic                   p1_wr;
  logic [BYTE_ADDR_W-1:0] p1_baddr;

  // stage two
  cmd_t                   p2_cmd;
  logic [PW-1:0]          p2_prod;
  logic [DW-1:0]          p2_px;
  logic [GRAY_W-1:0]      p2_gray;
  logic                   p2_wr;
  logic [BYTE_ADDR_W-1:0] p2_baddr;

  // stage three
  logic              p3_write;
  logic              p3_read;
  logic              p3_low;
  logic [GRAY_W-1:0] p3_gray;
  logic [AW-1:0]     p3_addr;
  logic [BYTE_W-1:0] rdata;
  logic              fwd_hit;
  logic [BYTE_W-1:0] fwd_byte;

  // output register
  logic [BYTE_W-1:0] res_read_byte;
  logic              res_written;

  logic [BYTE_W-1:0] mem [STORE_BYTES];

  // --------------------------------------------------------------------------
  // flow control
  // --------------------------------------------------------------------------
  assign out_free = !res_valid || result.ready;
  assign p3_adv   = p3_valid && out_free;
  assign p3_free  = !p3_valid || out_free;
  assign p2_adv   = p2_valid && p3_free;
  assign p2_free  = !p2_valid || p3_free;
  assign p1_adv   = p1_valid && p2_free;
  assign p1_free  = !p1_valid || p2_free;

  assign pixel.ready = p1_free;
  assign in_fire     = pixel.valid && p1_free;
  assign cfg.ready   = 1'b1;
  assign cfg_fire    = cfg.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      p3_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (p1_free) begin
        p1_valid <= pixel.valid;
      end
      if (p2_free) begin
        p2_valid <= p1_valid;
      end
      if (p3_free) begin
        p3_valid <= p2_valid;
      end
      if (out_free) begin
        res_valid <= p3_valid;
      end
    end
  end

  // --------------------------------------------------------------------------
  // configuration registers and stream cursor
  // --------------------------------------------------------------------------
  logic             exh_now;
  logic [REG_W-1:0] x_inc;
  logic [REG_W-1:0] y_inc;

  assign exh_now = window_exhausted || (cursor_y >= window_bottom)
                   || (window_left >= window_right);
  assign x_inc   = cursor_x + 1'b1;
  assign y_inc   = cursor_y + 1'b1;

  always_comb begin
    cursor_x_next         = cursor_x;
    cursor_y_next         = cursor_y;
    row_start_next        = row_start;
    window_exhausted_next = window_exhausted;
    if (cfg_fire) begin
      case (cfg.index)
        REG_WINDOW_LEFT: begin
          cursor_x_next         = cfg.data;
          cursor_y_next         = row_start;
          window_exhausted_next = 1'b0;
        end
        REG_WINDOW_RIGHT, REG_WINDOW_BOTTOM: begin
          cursor_x_next         = window_left;
          cursor_y_next         = row_start;
          window_exhausted_next = 1'b0;
        end
        REG_WINDOW_TOP: begin
          row_start_next        = cfg.data;
          cursor_x_next         = window_left;
          cursor_y_next         = cfg.data;
          window_exhausted_next = 1'b0;
        end
        default: begin
        end
      endcase
    end else if (in_fire && pixel.command == CMD_STREAM) begin
      window_exhausted_next = exh_now;
      if (!exh_now) begin
        if (x_inc >= window_right) begin
          cursor_x_next = window_left;
          cursor_y_next = y_inc;
        end else begin
          cursor_x_next = x_inc;
        end
        if (pixel.last_pixel) begin
          row_start_next = y_inc;
        end
      end
      if (pixel.last_pixel) begin
        cursor_x_next         = window_left;
        cursor_y_next         = row_start_next;
        window_exhausted_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation         <= '0;
      frame_width      <= 11'd960;
      frame_height     <= 11'd540;
      window_left      <= '0;
      window_right     <= '0;
      window_bottom    <= '0;
      cursor_x         <= '0;
      cursor_y         <= '0;
      row_start        <= '0;
      window_exhausted <= 1'b0;
    end else begin
      cursor_x         <= cursor_x_next;
      cursor_y         <= cursor_y_next;
      row_start        <= row_start_next;
      window_exhausted <= window_exhausted_next;
      if (cfg_fire) begin
        case (cfg.index)
          REG_ROTATION:      rotation      <= cfg.data[ROT_W-1:0];
          REG_FRAME_WIDTH:   frame_width   <= cfg.data;
          REG_FRAME_HEIGHT:  frame_height  <= cfg.data;
          REG_WINDOW_LEFT:   window_left   <= cfg.data;
          REG_WINDOW_RIGHT:  window_right  <= cfg.data;
          REG_WINDOW_BOTTOM: window_bottom <= cfg.data;
          default: begin
          end
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage one capture
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_fire) begin
      p1_cmd        <= pixel.command;
      p1_gray_level <= pixel.gray_level;
      p1_color      <= pixel.swap_bytes
                       ? {pixel.pixel_rgb565[7:0], pixel.pixel_rgb565[15:8]}
                       : pixel.pixel_rgb565;
      p1_baddr      <= pixel.byte_address;
      if (pixel.command == CMD_STREAM) begin
        p1_x  <= COORD_W'(cursor_x);
        p1_y  <= COORD_W'(cursor_y);
        p1_wr <= !exh_now;
      end else begin
        p1_x  <= pixel.pixel_x;
        p1_y  <= pixel.pixel_y;
        p1_wr <= (pixel.command == CMD_DIRECT);
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage one: rotate, clip, gray conversion, row product
  // --------------------------------------------------------------------------
  logic [COORD_W-1:0] w16;
  logic [COORD_W-1:0] h16;
  logic [COORD_W-1:0] rx;
  logic [COORD_W-1:0] ry;
  logic               clip_ok;
  logic [SUM_W-1:0]   rgb_sum;
  logic [RECIP_W-1:0] rgb_scaled;
  logic [GRAY_W-1:0]  p1_gray;

  assign w16 = (COORD_W'(frame_width) > COORD_W'(MAX_DIM))
               ? COORD_W'(MAX_DIM) : COORD_W'(frame_width);
  assign h16 = (COORD_W'(frame_height) > COORD_W'(MAX_DIM))
               ? COORD_W'(MAX_DIM) : COORD_W'(frame_height);

  always_comb begin
    case (rotation)
      2'd1: begin
        rx = w16 - p1_y - 16'd1;
        ry = p1_x;
      end
      2'd2: begin
        rx = w16 - p1_x - 16'd1;
        ry = h16 - p1_y - 16'd1;
      end
      2'd3: begin
        rx = p1_y;
        ry = h16 - p1_x - 16'd1;
      end
      default: begin
        rx = p1_x;
        ry = p1_y;
      end
    endcase
  end

  assign clip_ok = (rx < w16) && (ry < h16);

  // (r8 + g8 + b8) / 48 by reciprocal
  assign rgb_sum    = SUM_W'({p1_color[15:11], 3'b000})
                      + SUM_W'({p1_color[10:5], 2'b00})
                      + SUM_W'({p1_color[4:0], 3'b000});
  assign rgb_scaled = (RECIP_W'(rgb_sum) * GRAY_RECIP) >> GRAY_SHIFT;
  assign p1_gray    = (p1_cmd == CMD_STREAM) ? rgb_scaled[GRAY_W-1:0] : p1_gray_level;

  always_ff @(posedge clk) begin
    if (p1_adv) begin
      p2_cmd   <= p1_cmd;
      p2_prod  <= ry[DW-1:0] * w16[DW-1:0];
      p2_px    <= rx[DW-1:0];
      p2_gray  <= p1_gray;
      p2_wr    <= p1_wr && clip_ok;
      p2_baddr <= p1_baddr;
    end
  end

  // --------------------------------------------------------------------------
  // stage two: byte address and store read
  // --------------------------------------------------------------------------
  logic [31:0]   p2_addr_full;
  logic          p2_in_range;
  logic [AW-1:0] p2_idx;
  logic          mem_we;
  logic [BYTE_W-1:0] cur_byte;
  logic [BYTE_W-1:0] mem_wdata;

  assign p2_addr_full = (p2_cmd == CMD_READ)
                        ? 32'(p2_baddr)
                        : 32'(p2_prod >> 1) + 32'(p2_px >> 1);
  assign p2_in_range  = p2_addr_full < 32'(STORE_BYTES);
  assign p2_idx       = p2_addr_full[AW-1:0];

  always_ff @(posedge clk) begin
    if (p2_adv) begin
      p3_write <= p2_wr && p2_in_range;
      p3_read  <= (p2_cmd == CMD_READ) && p2_in_range;
      p3_low   <= p2_px[0];
      p3_gray  <= p2_gray;
      p3_addr  <= p2_idx;
      fwd_hit  <= mem_we && (p3_addr == p2_idx);
      fwd_byte <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (p2_adv) begin
      rdata <= mem[p2_idx];
    end
    if (mem_we) begin
      mem[p3_addr] <= mem_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // stage three: nibble merge and write back
  // --------------------------------------------------------------------------
  assign cur_byte  = fwd_hit ? fwd_byte : rdata;
  assign mem_wdata = p3_low ? {cur_byte[7:4], p3_gray} : {p3_gray, cur_byte[3:0]};
  assign mem_we    = p3_adv && p3_write;

  always_ff @(posedge clk) begin
    if (p3_adv) begin
      res_read_byte <= p3_read ? cur_byte : '0;
      res_written   <= p3_write;
    end
  end

  assign result.valid         = res_valid;
  assign result.read_byte     = res_read_byte;
  assign result.pixel_written = res_written;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_written_no_byte: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.pixel_written |-> result.read_byte == '0)
    else $error("read byte set on a pixel write result");

  a_stall_from_output: assert property (@(posedge clk) disable iff (rst)
    !pixel.ready |-> result.valid && !result.ready)
    else $error("input stalled without output backpressure");

  a_cursor_in_window: assert property (@(posedge clk) disable iff (rst)
    !window_exhausted && (window_left < window_right)
      |-> (cursor_x >= window_left) && (cursor_x < window_right))
    else $error("stream cursor outside window");

  a_exhaust_by_stream: assert property (@(posedge clk) disable iff (rst)
    $rose(window_exhausted)
      |-> $past(pixel.valid && pixel.ready && pixel.command == CMD_STREAM))
    else $error("window exhausted without a stream transaction");

endmodule
